// File: sv/tad_pkg.sv
package tad_pkg;

	localparam int BLOCK_BYTES   = 512;
	localparam int OFF_W         = $clog2(BLOCK_BYTES);
	localparam int SIZE_W        = 33;
	localparam int SIZE_FIELD_AT = 124;
	localparam int SIZE_DIGITS   = 11;
	localparam int TYPE_AT       = 156;
	localparam int MAGIC_AT      = 257;
	localparam int MAGIC_LEN     = 5;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_FIVE = 8'h35;

	localparam logic [2:0] ROLE_HEADER  = 3'd0;
	localparam logic [2:0] ROLE_REGULAR = 3'd1;
	localparam logic [2:0] ROLE_OTHER   = 3'd2;
	localparam logic [2:0] ROLE_PAD     = 3'd3;
	localparam logic [2:0] ROLE_IGNORED = 3'd4;

	localparam logic [1:0] KIND_REGULAR = 2'd0;
	localparam logic [1:0] KIND_DIR     = 2'd1;
	localparam logic [1:0] KIND_OTHER   = 2'd2;

	localparam logic [1:0] STATUS_RUNNING  = 2'd0;
	localparam logic [1:0] STATUS_FINISHED = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_FINISHED,
		PH_ERROR
	} phase_t;

	// header summary as seen after the current beat
	typedef struct packed {
		logic              magic_ok;
		logic              all_zero;
		logic [SIZE_W-1:0] size;
		logic [1:0]        kind;
		logic              is_regular;
	} hdr_info_t;

	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		begin
			unique case (idx)
				3'd0: c = 8'h75; // u
				3'd1: c = 8'h73; // s
				3'd2: c = 8'h74; // t
				3'd3: c = 8'h61; // a
				3'd4: c = 8'h72; // r
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

endpackage

// File: sv/tar_archive_deframer.sv
// result: the result beat of an accepted byte is registered and is valid in the cycle after the byte is taken
// throughput: one byte per cycle; a byte is taken whenever the result register is
// empty or being drained in the same cycle
// reset: arst_n clears the block counter, the phase (back to header) and the
// header scan state at once; no result is pending after reset
module tar_archive_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  byte_role,
	output logic [tad_pkg::OFF_W-1:0]   block_offset,
	output logic                        header_done,
	output logic [1:0]                  entry_kind,
	output logic [tad_pkg::SIZE_W-1:0]  entry_size,
	output logic [1:0]                  archive_status
);
	import tad_pkg::*;

	phase_t            phase_q, phase_d;
	logic [OFF_W-1:0]  offset_q;
	logic [SIZE_W-1:0] content_left_q, content_left_d;
	logic [OFF_W-1:0]  padded_left_q, padded_left_d;
	logic [1:0]        zero_blocks_q, zero_blocks_d;
	logic              accept;
	logic              block_end;
	hdr_info_t         hdr;

	logic [2:0]        role_c;
	logic              done_c;
	logic [1:0]        kind_c;
	logic [SIZE_W-1:0] size_c;
	logic [1:0]        status_c;

	logic              out_valid_q;

	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;
	assign block_end = (offset_q == OFF_W'(BLOCK_BYTES - 1));

	tad_hdr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept && (phase_q == PH_HEADER)),
		.data_byte (data_byte),
		.offset    (offset_q),
		.info      (hdr)
	);

	// next state
	always_comb begin
		phase_d        = phase_q;
		content_left_d = content_left_q;
		padded_left_d  = padded_left_q;
		zero_blocks_d  = zero_blocks_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (block_end) begin
					if (hdr.magic_ok) begin
						zero_blocks_d  = 2'd0;
						content_left_d = hdr.size;
						padded_left_d  = OFF_W'(0) - hdr.size[OFF_W-1:0];
						if ((hdr.size != '0) || (padded_left_d != '0))
							phase_d = PH_DATA;
					end else if (hdr.all_zero) begin
						zero_blocks_d = zero_blocks_q + 2'd1;
						if (zero_blocks_d >= 2'd2)
							phase_d = PH_FINISHED;
					end else begin
						phase_d = PH_ERROR;
					end
				end
			end
			PH_DATA: begin
				if (content_left_q != '0)
					content_left_d = content_left_q - SIZE_W'(1);
				else if (padded_left_q != '0)
					padded_left_d = padded_left_q - OFF_W'(1);
				if ((content_left_d == '0) && (padded_left_d == '0))
					phase_d = PH_HEADER;
			end
			PH_FINISHED: phase_d = PH_FINISHED;
			PH_ERROR:    phase_d = PH_ERROR;
			default:     phase_d = PH_ERROR;
		endcase
	end

	// result fields
	always_comb begin
		role_c = ROLE_HEADER;
		done_c = 1'b0;
		kind_c = KIND_REGULAR;
		size_c = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (block_end && hdr.magic_ok) begin
					done_c = 1'b1;
					kind_c = hdr.kind;
					size_c = hdr.size;
				end
			end
			PH_DATA: begin
				if (content_left_q != '0)
					role_c = hdr.is_regular ? ROLE_REGULAR : ROLE_OTHER;
				else
					role_c = ROLE_PAD;
			end
			PH_FINISHED, PH_ERROR: role_c = ROLE_IGNORED;
			default: role_c = ROLE_IGNORED;
		endcase
		if (phase_d == PH_FINISHED)
			status_c = STATUS_FINISHED;
		else if (phase_d == PH_ERROR)
			status_c = STATUS_ERROR;
		else
			status_c = STATUS_RUNNING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			offset_q       <= '0;
			content_left_q <= '0;
			padded_left_q  <= '0;
			zero_blocks_q  <= 2'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			offset_q       <= offset_q + OFF_W'(1);
			content_left_q <= content_left_d;
			padded_left_q  <= padded_left_d;
			zero_blocks_q  <= zero_blocks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_ready)
			out_valid_q <= in_valid;
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_role      <= role_c;
			block_offset   <= offset_q;
			header_done    <= done_c;
			entry_kind     <= kind_c;
			entry_size     <= size_c;
			archive_status <= status_c;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted byte produced no result beat");

	a_done_at_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && header_done) |-> (block_offset == OFF_W'(BLOCK_BYTES - 1)))
		else $error("header_done away from last byte of block");

	a_data_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> ((content_left_q != '0) || (padded_left_q != '0)))
		else $error("data phase with nothing left");

	a_terminal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_FINISHED) || (phase_q == PH_ERROR)) |=> $stable(phase_q))
		else $error("left a terminal phase without reset");

endmodule

// File: sv/tad_hdr_scan.sv
module tad_hdr_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [7:0]                  data_byte,
	input  logic [tad_pkg::OFF_W-1:0]   offset,
	output tad_pkg::hdr_info_t          info
);
	import tad_pkg::*;

	logic              magic_ok_q;
	logic              all_zero_q;
	logic [SIZE_W-1:0] size_q;
	logic [7:0]        type_q;

	logic              magic_ok_d;
	logic              all_zero_d;
	logic [SIZE_W-1:0] size_d;
	logic              in_magic;
	logic              in_size;
	logic              block_end;
	logic [OFF_W-1:0]  magic_rel;

	assign block_end = (offset == OFF_W'(BLOCK_BYTES - 1));
	assign in_magic  = (offset >= OFF_W'(MAGIC_AT)) && (offset < OFF_W'(MAGIC_AT + MAGIC_LEN));
	assign in_size   = (offset >= OFF_W'(SIZE_FIELD_AT))
	                && (offset < OFF_W'(SIZE_FIELD_AT + SIZE_DIGITS));
	assign magic_rel = offset - OFF_W'(MAGIC_AT);

	always_comb begin
		all_zero_d = all_zero_q & (data_byte == 8'd0);
		magic_ok_d = magic_ok_q & ~(in_magic && (data_byte != magic_char(magic_rel[2:0])));
		// octal digit without range check, wraps at the field width
		if (in_size)
			size_d = {size_q[SIZE_W-4:0], 3'b000} + SIZE_W'(data_byte) - SIZE_W'(CHAR_ZERO);
		else
			size_d = size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_ok_q <= 1'b1;
			all_zero_q <= 1'b1;
			size_q     <= '0;
			type_q     <= 8'd0;
		end else if (en) begin
			if (offset == OFF_W'(TYPE_AT))
				type_q <= data_byte;
			if (block_end) begin
				magic_ok_q <= 1'b1;
				all_zero_q <= 1'b1;
				size_q     <= '0;
			end else begin
				magic_ok_q <= magic_ok_d;
				all_zero_q <= all_zero_d;
				size_q     <= size_d;
			end
		end
	end

	always_comb begin
		info.magic_ok   = magic_ok_d;
		info.all_zero   = all_zero_d;
		info.size       = size_d;
		info.is_regular = (type_q == CHAR_ZERO);
		if (type_q == CHAR_ZERO)
			info.kind = KIND_REGULAR;
		else if (type_q == CHAR_FIVE)
			info.kind = KIND_DIR;
		else
			info.kind = KIND_OTHER;
	end

endmodule
